// File: src/bbn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer package
// Shared constants, command codes and the queued job type.
// ----------------------------------------------------------------------------
package bbn_pkg;

   localparam int COORD_W = 32;
   localparam int EXT_W   = 33;
   localparam int TWICE_W = 35;
   localparam int MAG_W   = 33;
   localparam int FRAC_W  = 16;
   localparam int QUO_W   = MAG_W + FRAC_W;
   localparam int DEN_W   = 32;
   localparam int CNT_W   = $clog2(QUO_W);

   localparam logic [1:0] CMD_CLEAR     = 2'd0;
   localparam logic [1:0] CMD_MEASURE   = 2'd1;
   localparam logic [1:0] CMD_NORMALIZE = 2'd2;

   localparam logic signed [COORD_W-1:0] BOUND_LOW_START  = 32'sd655360000;
   localparam logic signed [COORD_W-1:0] BOUND_HIGH_START = -32'sd655360000;

   localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic signed [EXT_W-1:0]   ext_x;
      logic signed [EXT_W-1:0]   ext_y;
      logic signed [EXT_W-1:0]   ext_z;
      logic signed [TWICE_W-1:0] twice_x;
      logic signed [TWICE_W-1:0] twice_y;
      logic signed [TWICE_W-1:0] twice_z;
   } job_type;

endpackage
`default_nettype wire

// File: src/bbn_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one vertex command transaction with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface bbn_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [31:0] x_in;
   logic signed [31:0] y_in;
   logic signed [31:0] z_in;

   modport source (output valid, cmd, x_in, y_in, z_in, input ready);
   modport sink (input valid, cmd, x_in, y_in, z_in, output ready);
endinterface
`default_nettype wire

// File: src/bbn_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one normalized vertex transaction with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface bbn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_out;
   logic signed [31:0] y_out;
   logic signed [31:0] z_out;
   logic               degenerate;

   modport source (output valid, x_out, y_out, z_out, degenerate, input ready);
   modport sink (input valid, x_out, y_out, z_out, degenerate, output ready);
endinterface
`default_nettype wire

// File: src/bbn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer front end
// Accepts commands, keeps the running bounds and queues normalize jobs.
// ----------------------------------------------------------------------------
module bbn_front (
   input  wire logic     clock,
   input  wire logic     reset,
   bbn_req_if.sink       req_bus,
   output logic          push,
   output bbn_pkg::job_type push_job,
   input  wire logic     queue_full
);
   import bbn_pkg::*;

   logic signed [COORD_W-1:0] low_x_ff, low_y_ff, low_z_ff;
   logic signed [COORD_W-1:0] high_x_ff, high_y_ff, high_z_ff;
   logic                      accept;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign push          = accept && (req_bus.cmd == CMD_NORMALIZE);

   function automatic logic signed [EXT_W-1:0] extent(
      input logic signed [COORD_W-1:0] lo,
      input logic signed [COORD_W-1:0] hi
   );
      return {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
   endfunction

   function automatic logic signed [TWICE_W-1:0] twice_offset(
      input logic signed [COORD_W-1:0] v,
      input logic signed [COORD_W-1:0] lo,
      input logic signed [COORD_W-1:0] hi
   );
      return {{2{v[COORD_W-1]}}, v, 1'b0}
             - {{3{hi[COORD_W-1]}}, hi}
             - {{3{lo[COORD_W-1]}}, lo};
   endfunction

   always_comb begin
      push_job.ext_x   = extent(low_x_ff, high_x_ff);
      push_job.ext_y   = extent(low_y_ff, high_y_ff);
      push_job.ext_z   = extent(low_z_ff, high_z_ff);
      push_job.twice_x = twice_offset(req_bus.x_in, low_x_ff, high_x_ff);
      push_job.twice_y = twice_offset(req_bus.y_in, low_y_ff, high_y_ff);
      push_job.twice_z = twice_offset(req_bus.z_in, low_z_ff, high_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_x_ff  <= BOUND_LOW_START;
         low_y_ff  <= BOUND_LOW_START;
         low_z_ff  <= BOUND_LOW_START;
         high_x_ff <= BOUND_HIGH_START;
         high_y_ff <= BOUND_HIGH_START;
         high_z_ff <= BOUND_HIGH_START;
      end else if (accept) begin
         case (req_bus.cmd)
            CMD_CLEAR: begin
               low_x_ff  <= BOUND_LOW_START;
               low_y_ff  <= BOUND_LOW_START;
               low_z_ff  <= BOUND_LOW_START;
               high_x_ff <= BOUND_HIGH_START;
               high_y_ff <= BOUND_HIGH_START;
               high_z_ff <= BOUND_HIGH_START;
            end
            CMD_MEASURE: begin
               if (req_bus.x_in < low_x_ff) low_x_ff <= req_bus.x_in;
               if (req_bus.y_in < low_y_ff) low_y_ff <= req_bus.y_in;
               if (req_bus.z_in < low_z_ff) low_z_ff <= req_bus.z_in;
               if (req_bus.x_in > high_x_ff) high_x_ff <= req_bus.x_in;
               if (req_bus.y_in > high_y_ff) high_y_ff <= req_bus.y_in;
               if (req_bus.z_in > high_z_ff) high_z_ff <= req_bus.z_in;
            end
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: src/bbn_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer job queue
// Two-entry first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module bbn_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  bbn_pkg::job_type push_job,
   output logic             full,
   input  wire logic        pop,
   output bbn_pkg::job_type pop_job,
   output logic             empty
);
   import bbn_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// File: src/bbn_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer divider lane
// Unsigned restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbn_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bbn_pkg::QUO_W-1:0]   num,
   input  wire logic [bbn_pkg::DEN_W-1:0]   den,
   output logic                             done,
   output logic [bbn_pkg::QUO_W-1:0]        quo
);
   import bbn_pkg::*;

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [DEN_W:0]     shifted;
   logic [DEN_W:0]     diff;
   logic               fits;
   logic [DEN_W-1:0]   rem_in;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      shifted = {rem_ff, quo_ff[QUO_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(QUO_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         quo_ff <= num;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

endmodule
`default_nettype wire

// File: src/bbn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box normalizer back end
// Picks the largest extent, runs three divider lanes unless that extent is zero, and saturates results.
// ----------------------------------------------------------------------------
module bbn_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        empty,
   input  bbn_pkg::job_type pop_job,
   output logic             pop,
   bbn_rsp_if.source        rsp_bus
);
   import bbn_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PICK,
      S_PREP,
      S_DIV,
      S_HOLD
   } state_type;

   state_type                 state_ff;
   job_type                   job_ff;
   logic signed [EXT_W-1:0]   g_ff;
   logic                      neg_x_ff, neg_y_ff, neg_z_ff;
   logic [COORD_W-1:0]        res_x_ff, res_y_ff, res_z_ff;
   logic                      res_deg_ff;
   logic                      rsp_valid_ff;
   logic [COORD_W-1:0]        rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                      rsp_deg_ff;

   logic signed [EXT_W-1:0]   g_pick;
   logic [DEN_W-1:0]          den_mag;
   logic [QUO_W-1:0]          num_x, num_y, num_z;
   logic                      div_start;
   logic                      done_x, done_y, done_z;
   logic [QUO_W-1:0]          quo_x, quo_y, quo_z;
   logic                      rsp_free;

   function automatic logic [QUO_W-1:0] scaled_mag(input logic signed [TWICE_W-1:0] t);
      logic [TWICE_W-1:0] m;
      m = t[TWICE_W-1] ? (~t + 1'b1) : t;
      return {m[MAG_W-1:0], {FRAC_W{1'b0}}};
   endfunction

   function automatic logic [COORD_W-1:0] saturate(
      input logic [QUO_W-1:0] q,
      input logic             neg
   );
      logic [COORD_W-1:0] r;
      if (!neg) begin
         r = (|q[QUO_W-1:COORD_W-1]) ? SAT_MAX : q[COORD_W-1:0];
      end else begin
         if ((|q[QUO_W-1:COORD_W]) || (q[COORD_W-1] && (|q[COORD_W-2:0]))) begin
            r = SAT_MIN;
         end else begin
            r = ~q[COORD_W-1:0] + 1'b1;
         end
      end
      return r;
   endfunction

   always_comb begin
      g_pick = job_ff.ext_x;
      if (job_ff.ext_y > g_pick) g_pick = job_ff.ext_y;
      if (job_ff.ext_z > g_pick) g_pick = job_ff.ext_z;
   end

   always_comb begin
      logic [EXT_W-1:0] gm;
      gm      = g_ff[EXT_W-1] ? (~g_ff + 1'b1) : g_ff;
      den_mag = gm[DEN_W-1:0];
      num_x   = scaled_mag(job_ff.twice_x);
      num_y   = scaled_mag(job_ff.twice_y);
      num_z   = scaled_mag(job_ff.twice_z);
   end

   assign div_start = (state_ff == S_PREP) && (g_ff != '0);
   assign pop       = (state_ff == S_IDLE) && !empty;
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   bbn_div u_div_x (
      .clock (clock), .reset (reset), .start (div_start),
      .num (num_x), .den (den_mag), .done (done_x), .quo (quo_x)
   );

   bbn_div u_div_y (
      .clock (clock), .reset (reset), .start (div_start),
      .num (num_y), .den (den_mag), .done (done_y), .quo (quo_y)
   );

   bbn_div u_div_z (
      .clock (clock), .reset (reset), .start (div_start),
      .num (num_z), .den (den_mag), .done (done_z), .quo (quo_z)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.x_out      = rsp_x_ff;
   assign rsp_bus.y_out      = rsp_y_ff;
   assign rsp_bus.z_out      = rsp_z_ff;
   assign rsp_bus.degenerate = rsp_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_HOLD) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!empty) begin
                  job_ff   <= pop_job;
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               g_ff     <= g_pick;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               neg_x_ff <= job_ff.twice_x[TWICE_W-1] ^ g_ff[EXT_W-1];
               neg_y_ff <= job_ff.twice_y[TWICE_W-1] ^ g_ff[EXT_W-1];
               neg_z_ff <= job_ff.twice_z[TWICE_W-1] ^ g_ff[EXT_W-1];
               if (g_ff == '0) begin
                  res_x_ff   <= '0;
                  res_y_ff   <= '0;
                  res_z_ff   <= '0;
                  res_deg_ff <= 1'b1;
                  state_ff   <= S_HOLD;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (done_x && done_y && done_z) begin
                  res_x_ff   <= saturate(quo_x, neg_x_ff);
                  res_y_ff   <= saturate(quo_y, neg_y_ff);
                  res_z_ff   <= saturate(quo_z, neg_z_ff);
                  res_deg_ff <= 1'b0;
                  state_ff   <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (rsp_free) begin
                  rsp_x_ff     <= res_x_ff;
                  rsp_y_ff     <= res_y_ff;
                  rsp_z_ff     <= res_z_ff;
                  rsp_deg_ff   <= res_deg_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: src/bounding_box_unit_normalize.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounding box unit normalizer
// Tracks per-axis vertex bounds and maps vertices into the cube from -1 to 1.
// ----------------------------------------------------------------------------
// Clear and measure transactions update the running bounds at once, and a
// normalize transaction is snapshotted into a two-entry job queue. Every
// transaction is taken one per cycle as long as that queue has room. The back
// end finishes one normalize job at a time: it picks the scale, runs the three
// restoring divider lanes that each retire one of 49 quotient bits per
// cycle, and then hands the result to the output register when it is free.
// A job with zero scale skips the divide.
module bounding_box_unit_normalize (
   input  wire logic clock,
   input  wire logic reset,
   bbn_req_if.sink   req_bus,
   bbn_rsp_if.source rsp_bus
);
   import bbn_pkg::*;

   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   job_type push_job;
   job_type pop_job;

   bbn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_job   (push_job),
      .queue_full (full)
   );

   bbn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   bbn_back u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (empty),
      .pop_job (pop_job),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire
